>>> hw/rtl/can_frame_packet_ring_core_assert.svh
// Assertion macros for the CAN frame packet ring core.
// The checks compile only when SYNTH is not defined. They expect clk and rst in the
// including scope.
`ifndef CAN_FRAME_PACKET_RING_CORE_ASSERT_SVH
`define CAN_FRAME_PACKET_RING_CORE_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define CFPR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define CFPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFPR_ASSERT_SAME(label, ante, cons, msg)
`define CFPR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hw/rtl/cfpr_pkg.sv
// Shared types and constants for the CAN frame packet ring core.
// This file has no dependencies. The front end, the back end and the top level use it through scoped names.
package cfpr_pkg;

  // Input command codes.
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_DRAINED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // A drain emits no more than this many results.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 4;

  typedef struct packed {
    logic        cmd;
    logic        rtr;
    logic [3:0]  dlc;
    logic [10:0] std_id;
    logic [63:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  header_byte;
    logic [10:0] id_out;
    logic [63:0] data_out;
    logic        last;
    logic [7:0]  held_after;
  } out_item_t;

  // This is the kind of work that the front end hands to the back end.
  typedef enum logic [1:0] {
    K_PUSH  = 2'd0,
    K_FULL  = 2'd1,
    K_DRAIN = 2'd2,
    K_EMPTY = 2'd3
  } kind_t;

  // This is one queued command. The slot address travels beside it because its
  // width follows the ring geometry.
  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] cnt_m1;
    logic [7:0]       held;
    logic [15:0]      meta;
    logic [63:0]      data;
  } cmd_t;

endpackage

>>> hw/rtl/cfpr_front.sv
// Front end of the CAN frame packet ring core. It accepts items, keeps the ring
// pointers and the frame count, and queues one classified command per item.
// It depends on cfpr_pkg.
module cfpr_front #(
  parameter int FRAMES_PER_PACKET = 16,
  parameter int PACKET_SLOTS      = 8,
  parameter int FRAME_LIMIT       = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cfpr_pkg::in_item_t   in_data,
  output logic                 q_push,
  input  logic                 q_full,
  output logic [$clog2(FRAMES_PER_PACKET*PACKET_SLOTS)-1:0] q_addr,
  output cfpr_pkg::cmd_t       q_cmd
);

  localparam int POS_W  = (FRAMES_PER_PACKET > 1) ? $clog2(FRAMES_PER_PACKET) : 1;
  localparam int PKT_W  = $clog2(PACKET_SLOTS);
  localparam int HELD_W = $clog2(FRAME_LIMIT + 1);
  localparam int SLOT_W = $clog2(FRAMES_PER_PACKET * PACKET_SLOTS);

  logic [POS_W-1:0]  wpos, wpos_next;
  logic [PKT_W-1:0]  wpkt, wpkt_next;
  logic [PKT_W-1:0]  rpkt, rpkt_next;
  logic [HELD_W-1:0] held, held_next;
  logic [HELD_W+7:0] held_ext;
  logic [SLOT_W-1:0] wslot, rslot;
  logic [4:0]        num;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign wslot = SLOT_W'(wpkt) * SLOT_W'(FRAMES_PER_PACKET) + SLOT_W'(wpos);
  assign rslot = SLOT_W'(rpkt) * SLOT_W'(FRAMES_PER_PACKET);

  always_comb begin
    wpos_next    = wpos;
    wpkt_next    = wpkt;
    rpkt_next    = rpkt;
    held_next    = held;
    num          = 5'd0;
    q_addr       = wslot;
    q_cmd.kind   = cfpr_pkg::K_EMPTY;
    q_cmd.cnt_m1 = '0;
    q_cmd.meta   = {in_data.rtr, in_data.dlc, in_data.std_id};
    q_cmd.data   = in_data.payload;
    unique case (in_data.cmd)
      cfpr_pkg::CMD_PUSH: begin
        if (32'(held) >= 32'(FRAME_LIMIT)) begin
          q_cmd.kind = cfpr_pkg::K_FULL;
        end else begin
          q_cmd.kind = cfpr_pkg::K_PUSH;
          held_next  = held + HELD_W'(1);
          if (32'(wpos) == 32'(FRAMES_PER_PACKET - 1)) begin
            wpos_next = '0;
            wpkt_next = (wpkt == PKT_W'(PACKET_SLOTS - 1)) ? '0 : wpkt + PKT_W'(1);
          end else begin
            wpos_next = wpos + POS_W'(1);
          end
        end
      end
      cfpr_pkg::CMD_DRAIN: begin
        q_addr = rslot;
        if (held != '0) begin
          q_cmd.kind = cfpr_pkg::K_DRAIN;
          if (32'(held) >= 32'(FRAMES_PER_PACKET)) begin
            num       = 5'(FRAMES_PER_PACKET);
            rpkt_next = (rpkt == PKT_W'(PACKET_SLOTS - 1)) ? '0 : rpkt + PKT_W'(1);
          end else begin
            // The partial packet is handed out and the write position restarts.
            num       = 5'(held);
            wpos_next = '0;
          end
          held_next    = held - HELD_W'(num);
          q_cmd.cnt_m1 = (num > 5'(cfpr_pkg::MAX_RESULTS)) ? '1
                                                            : cfpr_pkg::CNT_W'(num - 5'd1);
        end
      end
      default: begin
        q_cmd.kind = cfpr_pkg::K_EMPTY;
      end
    endcase
    held_ext   = {8'd0, held_next};
    q_cmd.held = held_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0;
      wpkt <= '0;
      rpkt <= '0;
      held <= '0;
    end else if (accept) begin
      wpos <= wpos_next;
      wpkt <= wpkt_next;
      rpkt <= rpkt_next;
      held <= held_next;
    end
  end

endmodule

>>> hw/rtl/cfpr_queue.sv
// Two-entry command queue between the front end and the back end of the ring core.
// It is generic over the entry width and does not use the package.
module cfpr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wptr, rptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_data   = entry[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr <= ~wptr;
      end
      if (rd_en) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

>>> hw/rtl/cfpr_back.sv
// Back end of the CAN frame packet ring core. It holds the frame memories, runs the
// queued commands and drives the registered result port.
// It depends on cfpr_pkg and can_frame_packet_ring_core_assert.svh.
`include "can_frame_packet_ring_core_assert.svh"

module cfpr_back #(
  parameter int FRAMES_PER_PACKET = 16,
  parameter int PACKET_SLOTS      = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic [$clog2(FRAMES_PER_PACKET*PACKET_SLOTS)-1:0] q_addr,
  input  cfpr_pkg::cmd_t       q_cmd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cfpr_pkg::out_item_t  out_data
);

  localparam int DEPTH  = FRAMES_PER_PACKET * PACKET_SLOTS;
  localparam int SLOT_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                        state, state_next;
  cfpr_pkg::cmd_t                cur;
  logic [SLOT_W-1:0]             addr, addr_next;
  logic [cfpr_pkg::CNT_W-1:0]    idx, idx_next;
  logic                          out_valid_next;
  cfpr_pkg::out_item_t           out_data_next;
  logic                          out_free, load, mem_we, last_frame;

  logic [15:0] meta_mem [DEPTH];
  logic [63:0] data_mem [DEPTH];
  logic [15:0] rd_meta;
  logic [63:0] rd_data;

  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && q_valid && out_free;
  assign mem_we     = q_pop && (q_cmd.kind == cfpr_pkg::K_PUSH);
  assign last_frame = (idx == cur.cnt_m1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      meta_mem[q_addr] <= q_cmd.meta;
      data_mem[q_addr] <= q_cmd.data;
    end
    rd_meta <= meta_mem[addr];
    rd_data <= data_mem[addr];
  end

  always_comb begin
    state_next    = state;
    addr_next     = addr;
    idx_next      = idx;
    load          = 1'b0;
    out_data_next = out_data;
    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          out_data_next.header_byte = '0;
          out_data_next.id_out      = '0;
          out_data_next.data_out    = '0;
          out_data_next.last        = 1'b1;
          out_data_next.held_after  = q_cmd.held;
          unique case (q_cmd.kind)
            cfpr_pkg::K_PUSH: begin
              load                 = 1'b1;
              out_data_next.status = cfpr_pkg::ST_STORED;
            end
            cfpr_pkg::K_FULL: begin
              load                 = 1'b1;
              out_data_next.status = cfpr_pkg::ST_FULL;
            end
            cfpr_pkg::K_DRAIN: begin
              out_data_next.status = cfpr_pkg::ST_DRAINED;
              addr_next            = q_addr;
              idx_next             = '0;
              state_next           = S_READ;
            end
            default: begin
              load                 = 1'b1;
              out_data_next.status = cfpr_pkg::ST_EMPTY;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load                      = 1'b1;
          out_data_next.status      = cfpr_pkg::ST_DRAINED;
          out_data_next.header_byte = {3'b000, rd_meta[15:11]};
          out_data_next.id_out      = rd_meta[10:0];
          out_data_next.data_out    = rd_data;
          out_data_next.last        = last_frame;
          out_data_next.held_after  = cur.held;
          if (last_frame) begin
            state_next = S_IDLE;
          end else begin
            addr_next  = addr + SLOT_W'(1);
            idx_next   = idx + cfpr_pkg::CNT_W'(1);
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    addr     <= addr_next;
    idx      <= idx_next;
    out_data <= out_data_next;
  end

  `CFPR_ASSERT_NEXT(a_read_then_emit, state == S_READ, state == S_EMIT, "read not followed by emit")
  `CFPR_ASSERT_SAME(a_busy_is_drain, state != S_IDLE, cur.kind == cfpr_pkg::K_DRAIN, "busy without drain")
  `CFPR_ASSERT_SAME(a_idx_bound, state != S_IDLE, idx <= cur.cnt_m1, "frame index past count")
  `CFPR_ASSERT_NEXT(a_last_done, state == S_EMIT && out_free && last_frame, state == S_IDLE && out_valid && out_data.last, "last frame not closed")

endmodule

>>> hw/rtl/can_frame_packet_ring_core.sv
// CAN frame packet ring core: stores received standard-ID CAN frames in a ring of
// PACKET_SLOTS packets of FRAMES_PER_PACKET frames each, and hands them out a packet
// at a time. A push (cmd 0) gives exactly one result, "stored" or "refused full",
// and the ring refuses it once FRAME_LIMIT frames are held. A drain (cmd 1) gives one
// "drained" result per frame, at most 16, and marks the final one with last. A drain
// with nothing held gives a single "empty" result. When fewer than a full packet are
// held, a drain returns the partial packet and restarts the write position within the
// current packet. Timing: the front end takes one item per cycle while its two-entry
// command queue has room. The back end answers a push or an empty drain from its idle
// state. A drain goes from idle to the read state and then alternates the read and
// emit states per frame, as the frame memories are read through a register; an output
// stall holds the emit state, and no new command is taken until the last frame is out.
// The frame memories are not cleared after reset, and the block needs no clearing pass.
// Reading an unwritten slot returns undefined header, identifier and data fields.
// Depends on cfpr_pkg, cfpr_front, cfpr_queue and cfpr_back.
module can_frame_packet_ring_core #(
  parameter int FRAMES_PER_PACKET = 16,
  parameter int PACKET_SLOTS      = 8,
  parameter int FRAME_LIMIT       = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cfpr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cfpr_pkg::out_item_t out_data
);

  localparam int SLOT_W = $clog2(FRAMES_PER_PACKET * PACKET_SLOTS);
  localparam int Q_W    = SLOT_W + $bits(cfpr_pkg::cmd_t);

  // Commands from the front end travel through the queue as the slot address
  // packed above the command struct.
  logic              f_push, q_full, q_pop, q_valid;
  logic [SLOT_W-1:0] f_addr, b_addr;
  cfpr_pkg::cmd_t    f_cmd, b_cmd;
  logic [Q_W-1:0]    q_rd;

  cfpr_front #(
    .FRAMES_PER_PACKET (FRAMES_PER_PACKET),
    .PACKET_SLOTS      (PACKET_SLOTS),
    .FRAME_LIMIT       (FRAME_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (f_push),
    .q_full   (q_full),
    .q_addr   (f_addr),
    .q_cmd    (f_cmd)
  );

  cfpr_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (f_push),
    .wr_data   ({f_addr, f_cmd}),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_data   (q_rd),
    .not_empty (q_valid)
  );

  assign b_addr = q_rd[Q_W-1 -: SLOT_W];
  assign b_cmd  = cfpr_pkg::cmd_t'(q_rd[Q_W-SLOT_W-1:0]);

  // The back end owns the frame memories and the result register.
  cfpr_back #(
    .FRAMES_PER_PACKET (FRAMES_PER_PACKET),
    .PACKET_SLOTS      (PACKET_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_addr    (b_addr),
    .q_cmd     (b_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
